[rtl/ilid_pkg.sv]
// Shared types, codes and sizes for the indexed list block.
// Used by the list cells, the top level and the port checker.
package ilid_pkg;

  // Size of the list and derived widths
  localparam int CAPACITY  = 64;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 8;
  localparam int OPC_W     = 3;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int GRP_SIZE  = 8;
  localparam int NUM_GRPS  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // Request opcodes
  localparam logic [OPC_W-1:0] OP_READ = 3'd0;
  localparam logic [OPC_W-1:0] OP_HEAD = 3'd1;
  localparam logic [OPC_W-1:0] OP_TAIL = 3'd2;
  localparam logic [OPC_W-1:0] OP_AT   = 3'd3;
  localparam logic [OPC_W-1:0] OP_DEL  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } state_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

[rtl/ilid_cell.sv]
// One storage cell of the list row: holds one entry and shifts with its neighbours.
// Depends on ilid_pkg for the command struct and widths.
module ilid_cell import ilid_pkg::*; (
  input  logic             clk,
  input  logic [CMP_W-1:0] cell_idx,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] left_value,
  input  logic [VAL_W-1:0] right_value,
  output logic [VAL_W-1:0] cell_value,
  output logic [VAL_W-1:0] rd_word
);

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;

  // Pick own, new, left or right value
  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (cell_idx > cmd.pos) begin
        value_nxt = left_value;
      end else if (cell_idx == cmd.pos) begin
        value_nxt = cmd.value;
      end
    end else if (cmd.del) begin
      if (cell_idx >= cmd.pos) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // Drive the entry onto the read tree only when addressed
  assign rd_word    = (cell_idx == cmd.pos) ? value_r : '0;
  assign cell_value = value_r;

endmodule

[rtl/indexed_list_insert_delete_top.sv]
// Top level of the indexed list: request sequencer, row of list cells, read tree.
// Depends on ilid_pkg and ilid_cell.
//
// Usage:
//   The in_ channel carries one request per beat: opcode in in_tuser, position
//   and value in in_tdata. The out_ channel returns one result beat for every
//   request: status in out_tuser, read value in out_tdata.
//   A request is applied to the cell row in the cycle after it is accepted;
//   inserts and deletes move every entry behind the position by one place
//   in that same cycle. The read value goes through a two-level OR tree
//   whose first level is registered, and the result beat is then loaded
//   into the output register once that register is free.
//   The block takes no new request until the accept, apply and result
//   steps of the sequencer are through.
//   Reset clears the entry count and the handshake state and holds in_tready
//   low; the stored entries are not cleared and are only read below the count.
//   A stalled receiver holds the result in the output register; the next
//   request is still accepted and applied, and its result waits in the
//   sequencer, with in_tready low, until the output register is free.
module indexed_list_insert_delete_top import ilid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] item_value
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;

  // Request and result holding registers
  logic [OPC_W-1:0]  req_opc_r;
  logic [POS_W-1:0]  req_pos_r;
  logic [VAL_W-1:0]  req_val_r;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              res_miss_r, res_miss_nxt;
  logic [VAL_W-1:0]  grp_or_r [NUM_GRPS];
  logic [STAT_W-1:0] out_stat_r;
  logic [VAL_W-1:0]  out_data_r;

  // Sequencer controls
  logic              req_load;
  logic              exec_en;
  logic              out_load;

  // Cell row signals
  cell_cmd_t         cmd;
  logic [VAL_W-1:0]  cell_vals [CAPACITY];
  logic [VAL_W-1:0]  rd_words  [CAPACITY];
  logic [VAL_W-1:0]  grp_or_nxt [NUM_GRPS];
  logic [VAL_W-1:0]  tree_out;

  // Decode of the held request
  logic [CMP_W-1:0]  pos_ext, cnt_ext, ins_pos;
  logic              is_ins, ins_ok, del_ok;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    exec_en   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = rst_n;
      ST_EXEC:   exec_en   = 1'b1;
      ST_RESULT: out_load  = !out_valid_r || out_tready;
      default:   in_tready = 1'b0;
    endcase
  end

  assign req_load = in_tvalid && in_tready;

  // Decide the request against the current count
  assign pos_ext = CMP_W'(req_pos_r);
  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    is_ins       = 1'b0;
    ins_pos      = pos_ext;
    del_ok       = 1'b0;
    res_stat_nxt = STAT_DONE;
    res_hit_nxt  = 1'b0;
    res_miss_nxt = 1'b0;
    unique case (req_opc_r)
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          res_hit_nxt = 1'b1;
        end else begin
          res_miss_nxt = 1'b1;
          res_stat_nxt = STAT_RANGE;
        end
      end
      OP_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      OP_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt_ext;
      end
      OP_AT: begin
        is_ins  = 1'b1;
      end
      OP_DEL: begin
        if (pos_ext < cnt_ext) begin
          del_ok = 1'b1;
        end else begin
          res_stat_nxt = STAT_RANGE;
        end
      end
      default: begin
        res_stat_nxt = STAT_DONE;
      end
    endcase
    ins_ok = 1'b0;
    if (is_ins) begin
      priority if (ins_pos > cnt_ext) begin
        res_stat_nxt = STAT_RANGE;
      end else if (cnt_ext == CMP_W'(CAPACITY)) begin
        res_stat_nxt = STAT_FULL;
      end else begin
        ins_ok = 1'b1;
      end
    end
  end

  // Broadcast the command to the row
  always_comb begin
    cmd.ins   = exec_en && ins_ok;
    cmd.del   = exec_en && del_ok;
    cmd.pos   = is_ins ? ins_pos : pos_ext;
    cmd.value = req_val_r;
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) count_nxt = count_r + CNT_W'(1);
    else if (cmd.del) count_nxt = count_r - CNT_W'(1);
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_vals[i];
    end else begin : g_left
      assign left_v = cell_vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_vals[i];
    end else begin : g_right
      assign right_v = cell_vals[i+1];
    end
    ilid_cell u_cell (
      .clk         (clk),
      .cell_idx    (CMP_W'(i)),
      .cmd         (cmd),
      .left_value  (left_v),
      .right_value (right_v),
      .cell_value  (cell_vals[i]),
      .rd_word     (rd_words[i])
    );
  end

  // First level of the read tree: OR each group of cells
  always_comb begin
    for (int g = 0; g < NUM_GRPS; g++) begin
      grp_or_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_or_nxt[g] = grp_or_nxt[g] | rd_words[g * GRP_SIZE + k];
        end
      end
    end
  end

  // Second level of the read tree
  always_comb begin
    tree_out = '0;
    for (int g = 0; g < NUM_GRPS; g++) begin
      tree_out = tree_out | grp_or_r[g];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold request, latch decision and read groups, load result
  always_ff @(posedge clk) begin
    if (req_load) begin
      req_opc_r <= in_tuser;
      req_pos_r <= in_tdata[7:0];
      req_val_r <= in_tdata[39:8];
    end
    if (exec_en) begin
      res_stat_r <= res_stat_nxt;
      res_hit_r  <= res_hit_nxt;
      res_miss_r <= res_miss_nxt;
      for (int g = 0; g < NUM_GRPS; g++) begin
        grp_or_r[g] <= grp_or_nxt[g];
      end
    end
    if (out_load) begin
      out_stat_r <= res_stat_r;
      priority if (res_hit_r) begin
        out_data_r <= tree_out;
      end else if (res_miss_r) begin
        out_data_r <= '1;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

[rtl/ilid_checker.sv]
// Port-level checker for the indexed list top level, with its bind statement.
// Depends on ilid_pkg for the status codes.
module ilid_checker import ilid_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Status is one of the defined codes
  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_DONE || out_tuser == STAT_RANGE ||
                    out_tuser == STAT_FULL))
    else $error("undefined status code");

  // A full list result carries a zero value
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_FULL |-> out_tdata == 32'd0)
    else $error("full status with non-zero value");

  // Busy right after a request beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in flight");

endmodule

bind indexed_list_insert_delete_top ilid_checker u_ilid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/sv/indexed_list_insert_delete_top_tb.sv]
// Self-checking bench for the indexed list block: drives request beats, predicts each
// result from a shadow copy of the list and compares every result beat in order.
// Depends on ilid_pkg and indexed_list_insert_delete_top.
module indexed_list_insert_delete_top_tb;
  import ilid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block does not use; they must leave the list alone
  localparam logic [OPC_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OPC_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_RSVD7 = 3'd7;

  localparam logic [VAL_W-1:0] READ_MISS  = 32'hFFFF_FFFF;
  localparam int               QUIET_TAIL = 150;
  localparam int               DRAIN_WAIT = 20;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } list_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
  } list_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [39:0]       in_tdata;   // [7:0] position, [39:8] item_value
  logic [2:0]        in_tuser;   // [2:0] opcode
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;  // [31:0] read_value
  logic [1:0]        out_tuser;  // [1:0] status

  // Shadow of the list contents as the block should hold them
  logic [VAL_W-1:0]  list_vals [CAPACITY];
  int unsigned       list_len;
  int unsigned       peak_len;

  list_req_t         pend_q [$];
  list_result_t      result_q [$];
  list_req_t         cur_req;
  bit                holding;
  bit                beat_taken;
  int unsigned       send_gap;
  int unsigned       stall_cnt;
  int unsigned       gen_len;
  int unsigned       cyc;
  int unsigned       err_cnt;
  int unsigned       n_req;
  int unsigned       n_res;
  int unsigned       n_range;
  int unsigned       n_full;
  int unsigned       n_hits;

  indexed_list_insert_delete_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Insert before a position, shifting the tail up by one
  function automatic logic [STAT_W-1:0] list_insert(int unsigned at, logic [VAL_W-1:0] v);
    int unsigned i;
    if (at > list_len) return STAT_RANGE;
    if (list_len >= CAPACITY) return STAT_FULL;
    for (i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
    list_vals[at] = v;
    list_len++;
    if (list_len > peak_len) peak_len = list_len;
    return STAT_DONE;
  endfunction

  // Remove one entry, closing the gap
  function automatic logic [STAT_W-1:0] list_delete(int unsigned at);
    int unsigned i;
    if (at >= list_len) return STAT_RANGE;
    for (i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
    return STAT_DONE;
  endfunction

  // Apply one request to the shadow list and return the result it should give
  function automatic list_result_t apply_request(list_req_t rq);
    list_result_t rs;
    rs.status     = STAT_DONE;
    rs.read_value = '0;
    case (rq.opcode)
      OP_READ: begin
        if (rq.position < list_len) begin
          rs.read_value = list_vals[rq.position];
        end else begin
          rs.status     = STAT_RANGE;
          rs.read_value = READ_MISS;
        end
      end
      OP_HEAD: rs.status = list_insert(0, rq.item_value);
      OP_TAIL: rs.status = list_insert(list_len, rq.item_value);
      OP_AT:   rs.status = list_insert(32'(rq.position), rq.item_value);
      OP_DEL:  rs.status = list_delete(32'(rq.position));
      default: ;
    endcase
    return rs;
  endfunction

  // Queue a request and track the list length it leaves behind, so that
  // later positions can be aimed at the live range
  function automatic void push_req(logic [OPC_W-1:0] op, int unsigned pos,
                                   logic [VAL_W-1:0] v);
    list_req_t rq;
    rq.opcode     = op;
    rq.position   = pos[POS_W-1:0];
    rq.item_value = v;
    pend_q.push_back(rq);
    case (op)
      OP_HEAD, OP_TAIL: if (gen_len < CAPACITY) gen_len++;
      OP_AT:            if (rq.position <= gen_len && gen_len < CAPACITY) gen_len++;
      OP_DEL:           if (rq.position < gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  // Mostly inside or at the edge of the list, sometimes far beyond it
  function automatic int unsigned pick_pos(int unsigned len);
    case ($urandom_range(0, 9))
      0:       return 255;
      1:       return $urandom_range(0, 255);
      2:       return len;
      3:       return (len > 0) ? len - 1 : 0;
      default: return $urandom_range(0, len);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Idle only outside the calm stretches and never near the end
  function automatic bit may_idle();
    return (pend_q.size() >= QUIET_TAIL) && (cyc[8:7] != 2'b11);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch, %s: expected %h, got %h", $realtime, what, want, got);
    err_cnt++;
  endtask

  // Request driver: hold the beat until taken, then advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (beat_taken) begin
        beat_taken = 1'b0;
        holding    = 1'b0;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pend_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (may_idle() && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 8) - 1;
          in_tvalid <= 1'b0;
        end else begin
          cur_req = pend_q.pop_front();
          holding = 1'b1;
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_req.item_value, cur_req.position};
          in_tuser  <= cur_req.opcode;
        end
      end
    end
  end

  // Result receiver: stall in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready <= 1'b0;
    end else if (may_idle() && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(1, 8) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      cyc++;
      if (in_tvalid && in_tready) begin
        result_q.push_back(apply_request(cur_req));
        beat_taken = 1'b1;
        n_req++;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", '0, out_tdata);
        end else begin
          want = result_q.pop_front();
          n_res++;
          if (want.status == STAT_RANGE) n_range++;
          if (want.status == STAT_FULL) n_full++;
          if (want.status == STAT_DONE && want.read_value != 0) n_hits++;
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_tuser));
          if (out_tdata !== want.read_value)
            report_mismatch("read_value", want.read_value, out_tdata);
        end
      end
    end
  end

  initial begin
    int unsigned seg_left;
    int          ins_w;
    int          del_w;
    int unsigned r;
    int unsigned i;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;

    // Directed: empty list misses, inserts at every place, reads, deletes, reserved opcodes
    push_req(OP_READ, 0, 32'h0);
    push_req(OP_READ, 255, 32'h0);
    push_req(OP_DEL, 0, 32'h0);
    push_req(OP_AT, 1, 32'h1234_5678);
    push_req(OP_AT, 0, 32'h7FFF_FFFF);
    push_req(OP_HEAD, 0, 32'h8000_0000);
    push_req(OP_TAIL, 255, 32'hFFFF_FFFF);
    push_req(OP_AT, 1, 32'h5555_5555);
    push_req(OP_AT, 4, 32'hAAAA_AAAA);
    push_req(OP_AT, 255, 32'h0F0F_0F0F);
    for (i = 0; i < 6; i++) push_req(OP_READ, i, 32'hFFFF_FFFF);
    push_req(OP_DEL, 255, 32'h0);
    push_req(OP_DEL, 2, 32'h0);
    push_req(OP_DEL, 3, 32'h0);
    push_req(OP_DEL, 0, 32'h0);
    push_req(OP_RSVD5, 255, 32'hFFFF_FFFF);
    push_req(OP_RSVD6, 0, 32'h0);
    push_req(OP_RSVD7, 170, 32'h8000_0001);
    push_req(OP_READ, 1, 32'h0);

    // Random: phases that fill to capacity, drain, or churn around the middle
    ins_w    = 85;
    del_w    = 5;
    seg_left = 90;
    for (i = 0; i < 1300; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(30, 120);
        case ($urandom_range(0, 2))
          0:       begin ins_w = 65; del_w = 15; end
          1:       begin ins_w = 15; del_w = 60; end
          default: begin ins_w = 35; del_w = 35; end
        endcase
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < ins_w) begin
        case ($urandom_range(0, 3))
          0:       push_req(OP_HEAD, $urandom_range(0, 255), pick_value());
          1:       push_req(OP_TAIL, $urandom_range(0, 255), pick_value());
          default: push_req(OP_AT, pick_pos(gen_len), pick_value());
        endcase
      end else if (r < ins_w + del_w) begin
        push_req(OP_DEL, pick_pos(gen_len), $urandom);
      end else if (r < 97) begin
        push_req(OP_READ, pick_pos(gen_len), $urandom);
      end else begin
        case ($urandom_range(0, 2))
          0:       push_req(OP_RSVD5, $urandom_range(0, 255), $urandom);
          1:       push_req(OP_RSVD6, $urandom_range(0, 255), $urandom);
          default: push_req(OP_RSVD7, $urandom_range(0, 255), $urandom);
        endcase
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last request to go in, then for its result
    while (pend_q.size() != 0 || holding) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (result_q.size() != 0)
      report_mismatch("results never delivered", '0, result_q.size());
    $display("Sent %0d requests and compared %0d results; the list peaked at %0d of %0d.",
             n_req, n_res, peak_len, CAPACITY);
    $display("Out-of-range results: %0d, full rejections: %0d, non-zero read hits: %0d.",
             n_range, n_full, n_hits);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
